// ----- rtl/core/ccs_pkg.sv -----
package ccs_pkg;

    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned TEMP_W    = 8;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned SECONDS_W = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [SECONDS_W-1:0] PHASE_SECONDS_RST    = 16'd1200;
    localparam logic [TEMP_W-1:0]    WASH_TARGET_TEMP_RST = 8'd65;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SECONDS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WASH_TARGET_TEMP = 1'd1;

    localparam logic [FUNC_W-1:0] EV_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] EV_LEFT  = 2'd1;
    localparam logic [FUNC_W-1:0] EV_RIGHT = 2'd2;

    typedef enum logic [PHASE_W-1:0] {
        PH_WASH_READY   = 3'd0,
        PH_WASHING      = 3'd1,
        PH_RINSE_READY  = 3'd2,
        PH_RINSING      = 3'd3,
        PH_DIS_READY    = 3'd4,
        PH_DISINFECTING = 3'd5,
        PH_COMPLETE     = 3'd6
    } t_phase;

    typedef struct packed {
        logic [SECONDS_W-1:0] phase_seconds;
        logic [TEMP_W-1:0]    wash_target_temp;
    } t_cfg;

endpackage

// ----- rtl/core/ccs_in_if.sv -----
interface ccs_in_if;
    logic                         valid;
    logic                         ready;
    logic [ccs_pkg::FUNC_W-1:0]   func;
    logic [ccs_pkg::TEMP_W-1:0]   current_temp;

    modport source (output valid, output func, output current_temp, input ready);
    modport sink   (input valid, input func, input current_temp, output ready);
endinterface

// ----- rtl/core/ccs_out_if.sv -----
interface ccs_out_if;
    logic                            valid;
    logic                            ready;
    logic [ccs_pkg::PHASE_W-1:0]     phase_now;
    logic                            pump_on;
    logic                            heater_on;
    logic [ccs_pkg::SECONDS_W-1:0]   seconds_left;
    logic                            exit_to_main;

    modport source (
        output valid, output phase_now, output pump_on, output heater_on,
        output seconds_left, output exit_to_main, input ready
    );
    modport sink (
        input valid, input phase_now, input pump_on, input heater_on,
        input seconds_left, input exit_to_main, output ready
    );
endinterface

// ----- rtl/core/ccs_cfg_regs.sv -----
module ccs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output ccs_pkg::t_cfg                 o_cfg
);
    import ccs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_seconds    <= PHASE_SECONDS_RST;
            r_cfg.wash_target_temp <= WASH_TARGET_TEMP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_SECONDS:    r_cfg.phase_seconds    <= i_cfg_data;
                CFG_WASH_TARGET_TEMP: r_cfg.wash_target_temp <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ccs_step.sv -----
module ccs_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ccs_pkg::t_cfg i_cfg,
    ccs_in_if.sink        i_in,
    ccs_out_if.source     o_out
);
    import ccs_pkg::*;

    t_phase               r_phase, n_phase;
    logic [SECONDS_W-1:0] r_remaining, n_remaining;
    logic                 r_pump, n_pump;
    logic                 r_heater, n_heater;
    logic                 r_leave, n_leave;
    logic                 r_valid;

    logic                 accept;
    logic                 active;
    logic [SECONDS_W-1:0] dec_remaining;
    t_phase               next_phase;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign active = (r_phase == PH_WASHING) || (r_phase == PH_RINSING) ||
                    (r_phase == PH_DISINFECTING);

    assign dec_remaining = (r_remaining != '0) ? r_remaining - 1'b1 : r_remaining;

    always_comb begin
        case (r_phase)
            PH_WASHING: next_phase = PH_RINSE_READY;
            PH_RINSING: next_phase = PH_DIS_READY;
            default:    next_phase = PH_COMPLETE;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_pump      = r_pump;
        n_heater    = r_heater;
        n_leave     = 1'b0;
        case (i_in.func)
            EV_TICK: begin
                if (active) begin
                    if (r_remaining != '0) begin
                        n_pump   = 1'b1;
                        n_heater = (r_phase == PH_WASHING) &&
                                   (i_in.current_temp < i_cfg.wash_target_temp);
                    end
                    n_remaining = dec_remaining;
                    if (dec_remaining == '0) begin
                        n_phase     = next_phase;
                        n_remaining = i_cfg.phase_seconds;
                        n_pump      = 1'b0;
                        n_heater    = 1'b0;
                    end
                end
            end
            EV_LEFT: begin
                n_phase  = PH_WASH_READY;
                n_pump   = 1'b0;
                n_heater = 1'b0;
                n_leave  = 1'b1;
            end
            EV_RIGHT: begin
                case (r_phase)
                    PH_WASHING, PH_RINSING, PH_DISINFECTING: begin
                        n_phase     = next_phase;
                        n_remaining = i_cfg.phase_seconds;
                        n_pump      = 1'b0;
                        n_heater    = 1'b0;
                    end
                    PH_WASH_READY: begin
                        n_phase     = PH_WASHING;
                        n_remaining = i_cfg.phase_seconds;
                    end
                    PH_RINSE_READY: n_phase = PH_RINSING;
                    PH_DIS_READY: begin
                        n_phase     = PH_DISINFECTING;
                        n_remaining = i_cfg.phase_seconds;
                    end
                    default: begin
                        n_phase  = PH_WASH_READY;
                        n_pump   = 1'b0;
                        n_heater = 1'b0;
                        n_leave  = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // state doubles as the result payload; it only advances on an accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WASH_READY;
            r_remaining <= '0;
            r_pump      <= 1'b0;
            r_heater    <= 1'b0;
            r_leave     <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_pump      <= n_pump;
                r_heater    <= n_heater;
                r_leave     <= n_leave;
            end
            if (i_in.ready) begin
                r_valid <= accept;
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.phase_now    = r_phase;
    assign o_out.pump_on      = r_pump;
    assign o_out.heater_on    = r_heater;
    assign o_out.seconds_left = r_remaining;
    assign o_out.exit_to_main = r_leave;

endmodule

// ----- rtl/core/cleaning_cycle_sequencer_top.sv -----
// Cleaning cycle sequencer for wash, rinse and disinfect. Each accepted event
// transaction (tick with temperature, left or right button) produces exactly
// one result transaction in the following cycle, carrying the phase, pump and heater
// drives, remaining seconds and the exit-to-main flag after that event. One
// event is taken every cycle as long as the result side keeps up; the single
// result register is the only stage, so a stalled result holds off the input.
// Configuration writes (0: phase seconds, 1: wash target temperature) take
// effect on the next cycle and are meant to be issued while no event is
// in flight.
module cleaning_cycle_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    ccs_in_if.sink                        i_in,
    ccs_out_if.source                     o_out
);
    import ccs_pkg::*;

    t_cfg cfg;

    ccs_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ccs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
